/* sv/fcr_pkg.sv */
package fcr_pkg;

	localparam logic [7:0] CRC_FEEDBACK   = 8'h9A;
	localparam logic [7:0] PREAMBLE_RESET = 8'hAA;
	localparam logic [7:0] CMD_BUZZER     = 8'h11;
	localparam logic [7:0] CMD_TEMP       = 8'h41;
	localparam logic [7:0] CMD_LIGHT      = 8'h42;
	localparam int         HEAD_DEPTH     = 4;

	// Frame parser phases, one-hot
	typedef enum logic [5:0] {
		PH_IDLE = 6'b000001,
		PH_SRC  = 6'b000010,
		PH_DST  = 6'b000100,
		PH_LEN  = 6'b001000,
		PH_DATA = 6'b010000,
		PH_CRC  = 6'b100000
	} fcr_phase_t;

	// One finished frame as seen on the result channel
	typedef struct packed {
		logic [7:0] src_addr;
		logic [7:0] dst_addr;
		logic [7:0] payload_len;
		logic [7:0] command_code;
		logic       crc_ok;
		logic       settings_applied;
		logic [7:0] buzzer_kind;
		logic [7:0] buzzer_low;
		logic [7:0] buzzer_high;
		logic [7:0] temp_limit;
		logic [7:0] light_limit;
	} fcr_result_t;

	// Reflected CRC-8, one byte, LSB first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] crc;
		logic [7:0] d;
		logic       fb;
		crc = crc_in;
		d   = data;
		for (int k = 0; k < 8; k++) begin
			fb  = crc[0] ^ d[0];
			crc = {1'b0, crc[7:1]};
			if (fb) begin
				crc = crc ^ CRC_FEEDBACK;
			end
			d = {1'b0, d[7:1]};
		end
		return crc;
	endfunction

endpackage

/* sv/fcr_parser.sv */
module fcr_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic [7:0]          preamble,
	output logic                emit,
	output fcr_pkg::fcr_result_t result
);
	import fcr_pkg::*;

	fcr_phase_t phase_q, phase_d;
	logic [7:0] src_q, src_d;
	logic [7:0] dst_q, dst_d;
	logic [7:0] len_q, len_d;
	logic [7:0] seen_q, seen_d;
	logic [7:0] crc_q, crc_d;
	logic [7:0] head_q [HEAD_DEPTH];
	logic [7:0] head_d [HEAD_DEPTH];
	logic [7:0] kind_q, kind_d;
	logic [7:0] low_q, low_d;
	logic [7:0] high_q, high_d;
	logic [7:0] temp_q, temp_d;
	logic [7:0] light_q, light_d;
	logic [7:0] crc_step;
	logic [7:0] seen_inc;
	logic       ok;
	logic       applied;

	assign crc_step = crc8_byte((phase_q == PH_SRC) ? 8'd0 : crc_q, data_byte);
	assign seen_inc = seen_q + 8'd1;
	assign ok       = (data_byte == crc_q);

	// Next frame state for the byte in hand
	always_comb begin
		phase_d = phase_q;
		src_d   = src_q;
		dst_d   = dst_q;
		len_d   = len_q;
		seen_d  = seen_q;
		crc_d   = crc_q;
		head_d  = head_q;
		kind_d  = kind_q;
		low_d   = low_q;
		high_d  = high_q;
		temp_d  = temp_q;
		light_d = light_q;
		emit    = 1'b0;
		applied = 1'b0;
		unique case (phase_q)
			PH_SRC: begin
				src_d   = data_byte;
				crc_d   = crc_step;
				phase_d = PH_DST;
			end
			PH_DST: begin
				dst_d   = data_byte;
				crc_d   = crc_step;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				len_d  = data_byte;
				crc_d  = crc_step;
				seen_d = 8'd0;
				for (int i = 0; i < HEAD_DEPTH; i++) begin
					head_d[i] = 8'd0;
				end
				phase_d = (data_byte == 8'd0) ? PH_CRC : PH_DATA;
			end
			PH_DATA: begin
				if (seen_q < 8'(HEAD_DEPTH)) begin
					head_d[seen_q[1:0]] = data_byte;
				end
				crc_d  = crc_step;
				seen_d = seen_inc;
				if (seen_inc >= len_q) begin
					phase_d = PH_CRC;
				end
			end
			PH_CRC: begin
				emit = 1'b1;
				if (ok) begin
					unique case (head_q[0])
						CMD_BUZZER: begin
							kind_d  = head_q[1];
							low_d   = head_q[2];
							high_d  = head_q[3];
							applied = 1'b1;
						end
						CMD_TEMP: begin
							temp_d  = head_q[1];
							applied = 1'b1;
						end
						CMD_LIGHT: begin
							light_d = head_q[1];
							applied = 1'b1;
						end
						default: ;
					endcase
				end
				phase_d = PH_IDLE;
			end
			default: begin
				if (data_byte == preamble) begin
					phase_d = PH_SRC;
				end
			end
		endcase
	end

	// Result fields for the CRC byte
	always_comb begin
		result.src_addr         = src_q;
		result.dst_addr         = dst_q;
		result.payload_len      = len_q;
		result.command_code     = head_q[0];
		result.crc_ok           = ok;
		result.settings_applied = applied;
		result.buzzer_kind      = kind_d;
		result.buzzer_low       = low_d;
		result.buzzer_high      = high_d;
		result.temp_limit       = temp_d;
		result.light_limit      = light_d;
	end

	// Advance frame state by one byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			src_q   <= 8'd0;
			dst_q   <= 8'd0;
			len_q   <= 8'd0;
			seen_q  <= 8'd0;
			crc_q   <= 8'd0;
			for (int i = 0; i < HEAD_DEPTH; i++) begin
				head_q[i] <= 8'd0;
			end
			kind_q  <= 8'd0;
			low_q   <= 8'd0;
			high_q  <= 8'd0;
			temp_q  <= 8'd0;
			light_q <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			src_q   <= src_d;
			dst_q   <= dst_d;
			len_q   <= len_d;
			seen_q  <= seen_d;
			crc_q   <= crc_d;
			head_q  <= head_d;
			kind_q  <= kind_d;
			low_q   <= low_d;
			high_q  <= high_d;
			temp_q  <= temp_d;
			light_q <= light_d;
		end
	end

endmodule

/* sv/framed_command_receiver.sv */
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   rx_byte
// result    out        out_valid / out_stall src_addr .. light_limit (11 fields)
// config    in         cfg_valid / cfg_ready preamble_value
//
// One byte is accepted per cycle, sustained, while the result side keeps up.
// A byte sits in the input register while the frame parser (eight
// unrolled CRC bit steps) works on it; a frame's result is registered into the output
// register as its CRC byte leaves the input register. When the output register
// is full and stalled, the parser holds, and a byte in the input register holds and in_stall rises.
// Reset clears the frame state and held settings and sets the preamble to 0xAA; cfg_ready stays high.
module framed_command_receiver (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] preamble_value,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] src_addr,
	output logic [7:0] dst_addr,
	output logic [7:0] payload_len,
	output logic [7:0] command_code,
	output logic       crc_ok,
	output logic       settings_applied,
	output logic [7:0] buzzer_kind,
	output logic [7:0] buzzer_low,
	output logic [7:0] buzzer_high,
	output logic [7:0] temp_limit,
	output logic [7:0] light_limit
);
	import fcr_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [7:0]  preamble_q;
	logic        out_valid_q;
	fcr_result_t result_q;
	fcr_result_t result;
	logic        emit;
	logic        advance;
	logic        step;

	// Move on when the output slot is empty or being taken
	assign advance   = !out_valid_q || !out_stall;
	assign step      = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	// Hold the preamble setting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_q <= PREAMBLE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			preamble_q <= preamble_value;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	fcr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.preamble  (preamble_q),
		.emit      (emit),
		.result    (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			result_q <= result;
		end
	end

	assign out_valid        = out_valid_q;
	assign src_addr         = result_q.src_addr;
	assign dst_addr         = result_q.dst_addr;
	assign payload_len      = result_q.payload_len;
	assign command_code     = result_q.command_code;
	assign crc_ok           = result_q.crc_ok;
	assign settings_applied = result_q.settings_applied;
	assign buzzer_kind      = result_q.buzzer_kind;
	assign buzzer_low       = result_q.buzzer_low;
	assign buzzer_high      = result_q.buzzer_high;
	assign temp_limit       = result_q.temp_limit;
	assign light_limit      = result_q.light_limit;

endmodule

/* sv/fcr_checker.sv */
module fcr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] src_addr,
	input logic [7:0] payload_len,
	input logic [7:0] command_code,
	input logic       crc_ok,
	input logic       settings_applied
);
	import fcr_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(src_addr))
		else $error("stalled result changed or dropped");

	// Apply settings only on a good CRC
	a_applied_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && settings_applied |-> crc_ok)
		else $error("settings applied with bad CRC");

	// Apply settings only for known commands
	a_applied_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && settings_applied |->
			(command_code == CMD_BUZZER || command_code == CMD_TEMP ||
			 command_code == CMD_LIGHT))
		else $error("settings applied for unknown command");

	// Empty frame carries no command
	a_empty_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_len == 8'd0 |-> command_code == 8'd0)
		else $error("command code on empty frame");

endmodule

bind framed_command_receiver fcr_checker u_fcr_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.src_addr         (src_addr),
	.payload_len      (payload_len),
	.command_code     (command_code),
	.crc_ok           (crc_ok),
	.settings_applied (settings_applied)
);

/* tb/framed_command_receiver_tb.sv */
module framed_command_receiver_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fcr_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 6;
	localparam int TAIL_CYCLES   = 20;
	localparam int MAX_REPORTS   = 10;

	logic       clk            = 1'b0;
	logic       arst_n         = 1'b0;
	logic       in_valid       = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte        = 8'h00;
	logic       cfg_valid      = 1'b0;
	logic       cfg_ready;
	logic [7:0] preamble_value = 8'h00;
	logic       out_valid;
	logic       out_stall      = 1'b0;
	logic [7:0] src_addr;
	logic [7:0] dst_addr;
	logic [7:0] payload_len;
	logic [7:0] command_code;
	logic       crc_ok;
	logic       settings_applied;
	logic [7:0] buzzer_kind;
	logic [7:0] buzzer_low;
	logic [7:0] buzzer_high;
	logic [7:0] temp_limit;
	logic [7:0] light_limit;

	framed_command_receiver DUT (.*);

	// Frame tracking mirror of the receiver
	fcr_phase_t  parse_phase = PH_IDLE;
	logic [7:0]  start_marker = PREAMBLE_RESET;
	logic [7:0]  hdr_src = 8'h00;
	logic [7:0]  hdr_dst = 8'h00;
	logic [7:0]  hdr_len = 8'h00;
	logic [7:0]  data_count = 8'h00;
	logic [7:0]  head_bytes[HEAD_DEPTH] = '{default: 8'h00};
	logic [7:0]  crc_acc = 8'h00;
	logic [7:0]  cur_buzz_kind = 8'h00;
	logic [7:0]  cur_buzz_low = 8'h00;
	logic [7:0]  cur_buzz_high = 8'h00;
	logic [7:0]  cur_temp_limit = 8'h00;
	logic [7:0]  cur_light_limit = 8'h00;
	fcr_result_t frames_due[$];

	logic [7:0]  frame_body[$];
	logic [7:0]  frame_bytes[$];
	int          busy_items = 0;
	int          calm_items = 0;
	int          mismatch_count = 0;
	int          cycle_count = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("framed_command_receiver verification failed");
			$finish;
		end
	end

	// Reflected CRC-8, LSB first
	function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] d);
		for (int i = 0; i < 8; i++) begin
			if (acc[0] ^ d[i]) begin
				acc = (acc >> 1) ^ CRC_FEEDBACK;
			end else begin
				acc = acc >> 1;
			end
		end
		return acc;
	endfunction

	// Advance the frame mirror by one accepted byte; queue the frame result on the CRC byte
	task automatic parse_byte(input logic [7:0] b);
		fcr_result_t res;
		logic        match;
		if (parse_phase != PH_IDLE || b == start_marker) begin
			busy_items++;
		end
		case (parse_phase)
			PH_SRC: begin
				hdr_src     = b;
				crc_acc     = crc_step(8'h00, b);
				parse_phase = PH_DST;
			end
			PH_DST: begin
				hdr_dst     = b;
				crc_acc     = crc_step(crc_acc, b);
				parse_phase = PH_LEN;
			end
			PH_LEN: begin
				hdr_len     = b;
				crc_acc     = crc_step(crc_acc, b);
				head_bytes  = '{default: 8'h00};
				data_count  = 8'h00;
				parse_phase = (b == 8'h00) ? PH_CRC : PH_DATA;
			end
			PH_DATA: begin
				if (data_count < HEAD_DEPTH) begin
					head_bytes[data_count[1:0]] = b;
				end
				crc_acc    = crc_step(crc_acc, b);
				data_count = data_count + 8'd1;
				if (data_count >= hdr_len) begin
					parse_phase = PH_CRC;
				end
			end
			PH_CRC: begin
				match = (b == crc_acc);
				res.settings_applied = 1'b0;
				if (match) begin
					if (head_bytes[0] == CMD_BUZZER) begin
						cur_buzz_kind = head_bytes[1];
						cur_buzz_low  = head_bytes[2];
						cur_buzz_high = head_bytes[3];
						res.settings_applied = 1'b1;
					end else if (head_bytes[0] == CMD_TEMP) begin
						cur_temp_limit = head_bytes[1];
						res.settings_applied = 1'b1;
					end else if (head_bytes[0] == CMD_LIGHT) begin
						cur_light_limit = head_bytes[1];
						res.settings_applied = 1'b1;
					end
				end
				res.src_addr     = hdr_src;
				res.dst_addr     = hdr_dst;
				res.payload_len  = hdr_len;
				res.command_code = head_bytes[0];
				res.crc_ok       = match;
				res.buzzer_kind  = cur_buzz_kind;
				res.buzzer_low   = cur_buzz_low;
				res.buzzer_high  = cur_buzz_high;
				res.temp_limit   = cur_temp_limit;
				res.light_limit  = cur_light_limit;
				frames_due.push_back(res);
				parse_phase = PH_IDLE;
			end
			default: begin
				if (b == start_marker) begin
					parse_phase = PH_SRC;
				end
			end
		endcase
	endtask

	// Mostly no gap, some short, a few long, with calm stretches
	function automatic int sender_gap();
		int r;
		if (calm_items > 0) begin
			calm_items--;
			return 0;
		end
		r = $urandom_range(99);
		if (r == 0) begin
			calm_items = $urandom_range(30, 90);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// Present one byte, hold it until taken, then idle for a random gap
	task automatic send_byte(input logic [7:0] b);
		int idle_n;
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		parse_byte(b);
		idle_n = sender_gap();
		if (idle_n > 0) begin
			in_valid <= 1'b0;
			rx_byte  <= 8'($urandom);
			repeat (idle_n) @(posedge clk);
		end
	endtask

	task automatic send_bytes(input int n);
		for (int i = 0; i < n; i++) begin
			send_byte(frame_bytes[i]);
		end
	endtask

	// Wrap frame_body with preamble, header and CRC into frame_bytes
	task automatic build_frame(input logic [7:0] src, input logic [7:0] dst, input bit bad_crc);
		logic [7:0] acc;
		logic [7:0] len;
		len = 8'(frame_body.size());
		frame_bytes.delete();
		frame_bytes.push_back(start_marker);
		frame_bytes.push_back(src);
		frame_bytes.push_back(dst);
		frame_bytes.push_back(len);
		acc = crc_step(crc_step(crc_step(8'h00, src), dst), len);
		foreach (frame_body[i]) begin
			frame_bytes.push_back(frame_body[i]);
			acc = crc_step(acc, frame_body[i]);
		end
		if (bad_crc) begin
			acc = acc ^ 8'($urandom_range(1, 255));
		end
		frame_bytes.push_back(acc);
	endtask

	task automatic send_frame(input logic [7:0] src, input logic [7:0] dst, input bit bad_crc);
		build_frame(src, dst, bad_crc);
		send_bytes(frame_bytes.size());
	endtask

	// Feed filler until the parser is back to hunting for a preamble
	task automatic finish_frame();
		while (parse_phase != PH_IDLE) begin
			if (parse_phase == PH_LEN) begin
				send_byte(8'($urandom_range(0, 12)));
			end else begin
				send_byte(8'($urandom));
			end
		end
	endtask

	// Hold the sender until every queued frame result has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (frames_due.size() != 0);
	endtask

	// Write the preamble only with the parser idle and the pipe empty
	task automatic write_preamble(input logic [7:0] v);
		finish_frame();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid      <= 1'b1;
		preamble_value <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid    <= 1'b0;
		start_marker = v;
	endtask

	// Random frame; cut_short leaves it unfinished for the following bytes to complete
	task automatic send_random_frame(input int len, input bit cut_short);
		int         r;
		int         n;
		logic [7:0] cmd;
		finish_frame();
		r = $urandom_range(99);
		if (r < 30) cmd = CMD_BUZZER;
		else if (r < 50) cmd = CMD_TEMP;
		else if (r < 70) cmd = CMD_LIGHT;
		else cmd = 8'($urandom);
		frame_body.delete();
		for (int i = 0; i < len; i++) begin
			frame_body.push_back((i == 0) ? cmd : 8'($urandom));
		end
		build_frame(8'($urandom), 8'($urandom), $urandom_range(99) < 15);
		n = cut_short ? $urandom_range(1, frame_bytes.size() - 1) : frame_bytes.size();
		send_bytes(n);
	endtask

	function automatic int pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 70) return $urandom_range(0, 6);
		if (r < 99) return $urandom_range(7, 24);
		return $urandom_range(25, 80);
	endfunction

	task automatic run_random_items(input int target);
		int first;
		int r;
		first = busy_items;
		while (busy_items - first < target) begin
			r = $urandom_range(99);
			if (r < 75) begin
				send_random_frame(pick_len(), 1'b0);
			end else if (r < 85) begin
				send_random_frame(pick_len(), 1'b1);
			end else if (r < 97) begin
				repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
			end else begin
				drain_results();
			end
		end
	endtask

	// Extreme byte values, empty frame, buzzer and temp commands, bad CRC, short frame
	task automatic test_directed_frames();
		send_byte(8'h00);
		frame_body.delete();
		send_frame(8'hFF, 8'hFF, 1'b0);
		frame_body = '{CMD_BUZZER, 8'hFF, 8'h00, 8'h80};
		send_frame(8'h00, 8'h01, 1'b0);
		frame_body = '{CMD_TEMP, 8'hFF};
		send_frame(8'h7F, 8'h80, 1'b1);
		frame_body = '{CMD_BUZZER};
		send_frame(8'h55, 8'hAA, 1'b0);
	endtask

	// Preamble extremes, long payload past the held bytes
	task automatic test_preamble_settings();
		write_preamble(8'h00);
		send_byte(PREAMBLE_RESET);
		frame_body = '{CMD_LIGHT, 8'h5A};
		send_frame(8'h12, 8'h34, 1'b0);
		write_preamble(8'hFF);
		send_byte(8'h00);
		frame_body = '{CMD_TEMP, 8'h3C, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
		send_frame(8'hC3, 8'h3C, 1'b0);
	endtask

	// Bulk random traffic over several preamble settings
	task automatic test_random_traffic();
		logic [7:0] markers[5];
		markers = '{8'($urandom), 8'h00, 8'hFF, 8'($urandom), PREAMBLE_RESET};
		for (int c = 0; c < 5; c++) begin
			write_preamble(markers[c]);
			run_random_items(125);
			drain_results();
			if (c == 2) begin
				send_random_frame(255, 1'b0);
			end
			run_random_items(125);
		end
	endtask

	// Random output stall: short bursts, rare long holds, calm stretches
	initial begin : stall_driver
		int r;
		@(posedge arst_n);
		forever begin
			out_stall <= 1'b0;
			r = $urandom_range(99);
			if (r < 10) repeat ($urandom_range(80, 200)) @(posedge clk);
			else if (r < 80) repeat ($urandom_range(1, 4)) @(posedge clk);
			else repeat ($urandom_range(5, 15)) @(posedge clk);
			r = $urandom_range(99);
			if (r < 70) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 2)) @(posedge clk);
			end else if (r < 95) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(3, 8)) @(posedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end
		end
	end

	task automatic note_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("MISMATCH at %0t ns: %s", $time, msg);
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			note_error($sformatf("%s expected %02h got %02h", name, want, got));
		end
	endtask

	// Compare each delivered frame result against the oldest expected one
	always @(posedge clk) begin : result_check
		fcr_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (frames_due.size() == 0) begin
				note_error("frame result with none outstanding");
			end else begin
				want = frames_due.pop_front();
				check_field("src_addr", want.src_addr, src_addr);
				check_field("dst_addr", want.dst_addr, dst_addr);
				check_field("payload_len", want.payload_len, payload_len);
				check_field("command_code", want.command_code, command_code);
				check_field("crc_ok", 8'(want.crc_ok), 8'(crc_ok));
				check_field("settings_applied", 8'(want.settings_applied), 8'(settings_applied));
				check_field("buzzer_kind", want.buzzer_kind, buzzer_kind);
				check_field("buzzer_low", want.buzzer_low, buzzer_low);
				check_field("buzzer_high", want.buzzer_high, buzzer_high);
				check_field("temp_limit", want.temp_limit, temp_limit);
				check_field("light_limit", want.light_limit, light_limit);
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frames();
		test_preamble_settings();
		test_random_traffic();
		in_valid <= 1'b0;
		while (frames_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("framed_command_receiver verification clean");
		end else begin
			$display("framed_command_receiver verification failed");
		end
		$finish;
	end

endmodule
